// ----- rtl/ccts_pkg.sv -----
package ccts_pkg;

    localparam int TOTAL_W     = 24;
    localparam int TIMEOUT_W   = 24;
    localparam int HOLD_W      = 8;
    localparam int SAMPLE_W    = 8;
    localparam int PHASE_W     = 3;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;

    // sequencer phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HOLD      = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CHARGE    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_PULSE     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DISCHARGE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD    = 4'd1;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd3100000;
    localparam logic [HOLD_W-1:0]    HOLD_RESET    = 8'd10;

    typedef struct packed {
        logic                start_req;
        logic [SAMPLE_W-1:0] sample_count;
        logic                receive_level;
    } item_t;

    typedef struct packed {
        logic               send_level;
        logic               receive_drive_enable;
        logic               receive_drive_level;
        logic               done_res;
        logic               timed_out;
        logic [TOTAL_W-1:0] total_ticks;
    } result_t;

endpackage

// ----- rtl/ccts_input_stage.sv -----
module ccts_input_stage
    import ccts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  advance,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- rtl/ccts_sequencer.sv -----
module ccts_sequencer
    import ccts_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  item_t                item,
    input  logic [TIMEOUT_W-1:0] timeout_ticks,
    input  logic [HOLD_W-1:0]    discharge_hold_ticks,
    output result_t              result
);

    localparam int CMP_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_next;
    logic [COUNT_WIDTH-1:0] tick_total_reg;
    logic [COUNT_WIDTH-1:0] tick_total_next;
    logic [SAMPLE_W-1:0]    samples_done_reg;
    logic [SAMPLE_W-1:0]    samples_done_next;
    logic [SAMPLE_W-1:0]    samples_wanted_reg;
    logic [SAMPLE_W-1:0]    samples_wanted_next;
    logic [HOLD_W-1:0]      hold_counter_reg;
    logic [HOLD_W-1:0]      hold_counter_next;

    logic [CMP_W-1:0]       total_ext;
    logic [CMP_W-1:0]       total_next_ext;
    logic [CMP_W-1:0]       timeout_ext;
    logic [HOLD_W-1:0]      hold_load;
    logic [SAMPLE_W-1:0]    samples_inc;
    logic                   below_timeout;
    logic                   may_count;
    logic                   done;
    logic                   tmo;

    assign total_ext     = CMP_W'(tick_total_reg);
    assign timeout_ext   = CMP_W'(timeout_ticks);
    assign below_timeout = total_ext < timeout_ext;
    assign may_count     = below_timeout && (tick_total_reg != {COUNT_WIDTH{1'b1}});
    assign hold_load     = (discharge_hold_ticks == '0) ? HOLD_W'(1) : discharge_hold_ticks;
    assign samples_inc   = samples_done_reg + SAMPLE_W'(1);

    always_comb
    begin
        phase_next          = phase_reg;
        tick_total_next     = tick_total_reg;
        samples_done_next   = samples_done_reg;
        samples_wanted_next = samples_wanted_reg;
        hold_counter_next   = hold_counter_reg;
        done                = 1'b0;
        tmo                 = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_req)
                begin
                    tick_total_next     = '0;
                    samples_done_next   = '0;
                    samples_wanted_next = item.sample_count;
                    if (item.sample_count == '0)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        phase_next        = PH_HOLD;
                        hold_counter_next = hold_load;
                    end
                end
            end
            PH_HOLD:
            begin
                hold_counter_next = hold_counter_reg - HOLD_W'(1);
                if (hold_counter_next == '0)
                begin
                    phase_next = PH_CHARGE;
                end
            end
            PH_CHARGE:
            begin
                if (!item.receive_level && may_count)
                begin
                    tick_total_next = tick_total_reg + COUNT_WIDTH'(1);
                end
                else if (total_ext > timeout_ext)
                begin
                    done       = 1'b1;
                    tmo        = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_PULSE;
                end
            end
            PH_PULSE:
            begin
                phase_next = PH_DISCHARGE;
            end
            PH_DISCHARGE:
            begin
                if (item.receive_level && may_count)
                begin
                    tick_total_next = tick_total_reg + COUNT_WIDTH'(1);
                end
                else if (!below_timeout)
                begin
                    done       = 1'b1;
                    tmo        = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    samples_done_next = samples_inc;
                    if (samples_inc == samples_wanted_reg)
                    begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next        = PH_HOLD;
                        hold_counter_next = hold_load;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign total_next_ext = CMP_W'(tick_total_next);

    // pin drives follow the phase entered on this tick
    always_comb
    begin
        result.send_level           = 1'b0;
        result.receive_drive_enable = 1'b0;
        result.receive_drive_level  = 1'b0;
        case (phase_next)
            PH_HOLD:
            begin
                result.receive_drive_enable = 1'b1;
            end
            PH_CHARGE:
            begin
                result.send_level = 1'b1;
            end
            PH_PULSE:
            begin
                result.send_level           = 1'b1;
                result.receive_drive_enable = 1'b1;
                result.receive_drive_level  = 1'b1;
            end
            default:
            begin
            end
        endcase
        result.done_res    = done;
        result.timed_out   = tmo;
        result.total_ticks = total_next_ext[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            tick_total_reg     <= '0;
            samples_done_reg   <= '0;
            samples_wanted_reg <= '0;
            hold_counter_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            tick_total_reg     <= tick_total_next;
            samples_done_reg   <= samples_done_next;
            samples_wanted_reg <= samples_wanted_next;
            hold_counter_reg   <= hold_counter_next;
        end
    end

endmodule

// ----- rtl/ccts_output_stage.sv -----
module ccts_output_stage
    import ccts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  result_t result_in,
    output logic    advance,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // take a new result when the slot is empty or being drained
    assign advance   = item_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_in;
        end
    end

endmodule

// ----- rtl/capacitive_charge_time_sensor_core.sv -----
// Capacitive touch sensor sequencer using the RC charge/discharge timing method.
// Input channel (in_valid/in_ready): one transaction per tick carrying start_req,
// sample_count and the sampled receive pin level. Output channel
// (out_valid/out_ready): exactly one result transaction per input transaction,
// carrying the pin drive levels for the next tick, done_res, timed_out and the
// running tick total.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 sets timeout_ticks,
// index 1 sets discharge_hold_ticks from cfg_data[7:0]; other indexes are dropped.
// Write registers only while no measurement is running.
// Path: an accepted input goes into the input register, then through the sequencer
// logic into the result register.
// Throughput: one transaction per cycle while out_ready is high; the sequencer state advances once per
// result loaded into the output register.
// Reset: sequencer goes idle, totals clear, registers take their default values
// (timeout 3100000 ticks, hold 10 ticks); both stages empty.
// Output stall: the result register holds; the input register takes a transaction
// only if it is empty, then in_ready drops until out_ready returns.
module capacitive_charge_time_sensor_core
    import ccts_pkg::*;
#(
    parameter int COUNT_WIDTH = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   start_req,
    input  logic [SAMPLE_W-1:0]    sample_count,
    input  logic                   receive_level,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   send_level,
    output logic                   receive_drive_enable,
    output logic                   receive_drive_level,
    output logic                   done_res,
    output logic                   timed_out,
    output logic [TOTAL_W-1:0]     total_ticks,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [HOLD_W-1:0]    hold_reg;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t step_result;
    result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            hold_reg    <= HOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                CFG_HOLD:    hold_reg    <= cfg_data[HOLD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_item.start_req     = start_req;
    assign in_item.sample_count  = sample_count;
    assign in_item.receive_level = receive_level;

    ccts_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ccts_sequencer #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_sequencer (
        .clk                  (clk),
        .rst_n                (rst_n),
        .step                 (advance),
        .item                 (item),
        .timeout_ticks        (timeout_reg),
        .discharge_hold_ticks (hold_reg),
        .result               (step_result)
    );

    ccts_output_stage u_output_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result_in  (step_result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign send_level           = result.send_level;
    assign receive_drive_enable = result.receive_drive_enable;
    assign receive_drive_level  = result.receive_drive_level;
    assign done_res             = result.done_res;
    assign timed_out            = result.timed_out;
    assign total_ticks          = result.total_ticks;

endmodule
